### sv/carrier_run_coalescer_macros.svh
// Assertion macros shared by the coalescer modules.
// The clocked forms disable themselves while reset is asserted.
`ifndef CARRIER_RUN_COALESCER_MACROS_SVH
`define CARRIER_RUN_COALESCER_MACROS_SVH

`ifndef SYNTHESIS

`define CRC_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("%m: assertion failed");

`define CRC_NEVER(lbl, clk_s, rst_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define CRC_ASSERT(lbl, clk_s, rst_s, prop)

`define CRC_NEVER(lbl, clk_s, rst_s, cond)

`endif

`endif

### sv/crc_pkg.sv
package crc_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_RUN  = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    // Carrier kinds.
    localparam logic [1:0] KIND_BLANK = 2'd0;
    localparam logic [1:0] KIND_MARK  = 2'd1;
    localparam logic [1:0] KIND_SPACE = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CODE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_CODE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_CODE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_CODE       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE        = 3'd6;

    localparam logic [31:0] NOISE_LIMIT_RST     = 32'd96;
    localparam logic [31:0] MIN_RUN_LENGTH_RST  = 32'd24;

    // Record body sizes.
    localparam logic [15:0] CARRIER_SIZE   = 16'h0008;
    localparam logic [15:0] DATA_SIZE_BASE = 16'd12;
    localparam logic [15:0] END_SIZE       = 16'h0000;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [31:0] noise_limit;
        logic [31:0] min_run_length;
        logic [15:0] blank_code;
        logic [15:0] mark_code;
        logic [15:0] space_code;
        logic [15:0] data_code;
        logic [15:0] end_code;
    } cfg_t;

    // One queue entry: an optional committed carrier run followed by an
    // optional data or end record.
    typedef struct packed {
        logic        c_valid;
        logic [1:0]  c_kind;
        logic [31:0] c_start;
        logic [31:0] c_length;
        logic        s_valid;
        logic        s_is_end;
        logic [31:0] s_start;
        logic [31:0] s_length;
        logic [15:0] s_bytes;
        logic [15:0] s_type;
    } cmd_t;

    typedef struct packed {
        logic [15:0] tag_code;
        logic [15:0] rec_size;
        logic [31:0] out_start;
        logic [31:0] out_length;
        logic [15:0] out_bytes;
        logic [15:0] out_type;
        logic        last;
    } rec_t;

    function automatic logic [15:0] kind_code(input cfg_t cfg, input logic [1:0] kind);
        logic [15:0] code;
        unique case (kind)
            KIND_MARK:  code = cfg.mark_code;
            KIND_SPACE: code = cfg.space_code;
            default:    code = cfg.blank_code;
        endcase
        return code;
    endfunction

endpackage

### sv/crc_in_if.sv
interface crc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [1:0]  carrier_kind;
    logic [31:0] seg_start;
    logic [31:0] seg_length;
    logic [15:0] block_bytes;
    logic [15:0] type_word;

    modport source (output valid, op, carrier_kind, seg_start, seg_length,
                    block_bytes, type_word, input ready);
    modport sink (input valid, op, carrier_kind, seg_start, seg_length,
                  block_bytes, type_word, output ready);
endinterface

### sv/crc_out_if.sv
interface crc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] tag_code;
    logic [15:0] rec_size;
    logic [31:0] out_start;
    logic [31:0] out_length;
    logic [15:0] out_bytes;
    logic [15:0] out_type;
    logic        last;

    modport source (output valid, tag_code, rec_size, out_start, out_length,
                    out_bytes, out_type, last, input ready);
    modport sink (input valid, tag_code, rec_size, out_start, out_length,
                  out_bytes, out_type, last, output ready);
endinterface

### sv/crc_front.sv
`include "carrier_run_coalescer_macros.svh"

module crc_front import crc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    crc_in_if.sink   in_ch,
    input  logic     q_full,
    output logic     push,
    output cmd_t     push_cmd
);

    logic [1:0]  pending_kind_reg,   pending_kind_next;
    logic [31:0] pending_start_reg,  pending_start_next;
    logic [31:0] pending_length_reg, pending_length_next;
    logic        end_done_reg,       end_done_next;

    logic        accept;
    logic [32:0] sum_wide;
    logic [31:0] sum_sat;
    logic        pend_active;
    logic        commit_emits;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    assign sum_wide     = {1'b0, pending_length_reg} + {1'b0, in_ch.seg_length};
    assign sum_sat      = sum_wide[32] ? '1 : sum_wide[31:0];
    assign pend_active  = (pending_length_reg != '0);
    assign commit_emits = pend_active && (pending_length_reg >= cfg.min_run_length);

    always_comb
    begin
        pending_kind_next   = pending_kind_reg;
        pending_start_next  = pending_start_reg;
        pending_length_next = pending_length_reg;
        end_done_next       = end_done_reg;

        push_cmd          = '0;
        push_cmd.c_kind   = pending_kind_reg;
        push_cmd.c_start  = pending_start_reg;
        push_cmd.c_length = pending_length_reg;
        push_cmd.s_start  = in_ch.seg_start;
        push_cmd.s_length = in_ch.seg_length;
        push_cmd.s_bytes  = in_ch.block_bytes;
        push_cmd.s_type   = in_ch.type_word;

        case (in_ch.op)
            OP_RUN:
            begin
                if (in_ch.seg_length != '0 && in_ch.carrier_kind <= KIND_SPACE)
                begin
                    if (pend_active && pending_kind_reg == in_ch.carrier_kind)
                    begin
                        pending_length_next = sum_sat;
                    end
                    else if (pend_active && pending_kind_reg == KIND_BLANK
                             && pending_length_reg < cfg.noise_limit
                             && in_ch.carrier_kind != KIND_BLANK)
                    begin
                        // A short leading blank is swallowed by the new run.
                        pending_kind_next   = in_ch.carrier_kind;
                        pending_length_next = sum_sat;
                    end
                    else if (pend_active && in_ch.carrier_kind == KIND_BLANK
                             && in_ch.seg_length < cfg.noise_limit
                             && pending_kind_reg != KIND_BLANK)
                    begin
                        pending_length_next = sum_sat;
                    end
                    else
                    begin
                        push_cmd.c_valid    = commit_emits;
                        pending_kind_next   = in_ch.carrier_kind;
                        pending_start_next  = in_ch.seg_start;
                        pending_length_next = in_ch.seg_length;
                    end
                end
            end
            OP_DATA:
            begin
                if (in_ch.block_bytes != '0)
                begin
                    push_cmd.c_valid    = commit_emits;
                    push_cmd.s_valid    = 1'b1;
                    pending_kind_next   = KIND_BLANK;
                    pending_length_next = '0;
                end
            end
            OP_END:
            begin
                if (!end_done_reg)
                begin
                    push_cmd.c_valid    = commit_emits;
                    push_cmd.s_valid    = 1'b1;
                    push_cmd.s_is_end   = 1'b1;
                    pending_kind_next   = KIND_BLANK;
                    pending_length_next = '0;
                    end_done_next       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign push = accept && (push_cmd.c_valid || push_cmd.s_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_kind_reg   <= KIND_BLANK;
            pending_start_reg  <= '0;
            pending_length_reg <= '0;
            end_done_reg       <= 1'b0;
        end
        else if (accept)
        begin
            pending_kind_reg   <= pending_kind_next;
            pending_start_reg  <= pending_start_next;
            pending_length_reg <= pending_length_next;
            end_done_reg       <= end_done_next;
        end
    end

    // An empty pending run always carries the blank kind.
    `CRC_ASSERT(a_idle_kind_blank, clk, rst_n,
        (pending_length_reg == '0) |-> (pending_kind_reg == KIND_BLANK))
    // The end record is sent once; the flag never clears outside reset.
    `CRC_NEVER(a_end_done_sticky, clk, rst_n, $fell(end_done_reg))

endmodule

### sv/crc_queue.sv
`include "carrier_run_coalescer_macros.svh"

module crc_queue import crc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CRC_NEVER(a_no_overflow, clk, rst_n, push && full && !pop)
    `CRC_NEVER(a_no_underflow, clk, rst_n, pop && empty)

endmodule

### sv/crc_back.sv
`include "carrier_run_coalescer_macros.svh"

module crc_back import crc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     q_empty,
    input  cmd_t     q_head,
    output logic     pop,
    crc_out_if.source out_ch
);

    logic out_valid_reg, out_valid_next;
    logic phase_reg,     phase_next;
    rec_t rec_reg;
    rec_t rec;
    logic sel_commit;
    logic final_rec;
    logic load;

    // Phase is set once the carrier record of a two-record entry is loaded.
    assign sel_commit = q_head.c_valid && !phase_reg;
    assign final_rec  = sel_commit ? !q_head.s_valid : 1'b1;
    assign load       = !q_empty && (!out_valid_reg || out_ch.ready);
    assign pop        = load && final_rec;

    always_comb
    begin
        rec = '0;
        if (sel_commit)
        begin
            rec.tag_code   = kind_code(cfg, q_head.c_kind);
            rec.rec_size   = CARRIER_SIZE;
            rec.out_start  = q_head.c_start;
            rec.out_length = q_head.c_length;
        end
        else if (q_head.s_is_end)
        begin
            rec.tag_code = cfg.end_code;
            rec.rec_size = END_SIZE;
        end
        else
        begin
            rec.tag_code   = cfg.data_code;
            rec.rec_size   = DATA_SIZE_BASE + q_head.s_bytes;
            rec.out_start  = q_head.s_start;
            rec.out_length = q_head.s_length;
            rec.out_bytes  = q_head.s_bytes;
            rec.out_type   = q_head.s_type;
        end
        rec.last = final_rec;

        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            phase_next     = !final_rec;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.tag_code   = rec_reg.tag_code;
    assign out_ch.rec_size   = rec_reg.rec_size;
    assign out_ch.out_start  = rec_reg.out_start;
    assign out_ch.out_length = rec_reg.out_length;
    assign out_ch.out_bytes  = rec_reg.out_bytes;
    assign out_ch.out_type   = rec_reg.out_type;
    assign out_ch.last       = rec_reg.last;

    // Mid-entry, the head must still be the two-record entry in progress.
    `CRC_ASSERT(a_phase_head, clk, rst_n,
        phase_reg |-> (!q_empty && q_head.c_valid && q_head.s_valid))

endmodule

### sv/carrier_run_coalescer.sv
// Carrier run coalescer.
// Input channel in_ch takes segment words: carrier runs, data blocks and the
// end-of-stream marker. Output channel out_ch delivers tag record headers;
// the last flag is set on the final record that one input word produces.
// Both channels move a word at a clock edge where valid and ready are high.
// Registers are written through cfg_we, cfg_index and cfg_data, one per
// cycle. The user must write them only while the block is idle; the block
// itself does not enforce this. The front stage merges runs and queues a
// command of up to two records into a four-entry queue. The back stage
// turns each command into one or two output words, one per cycle while
// out_ch is ready, through an output register. The command for a word is
// registered in a queue entry and its records in the output register
// before they reach out_ch. That output register, at one record per cycle,
// sets the sustained rate: two-record words go out more slowly.
// If the receiver stalls, the output word holds, the queue fills, and in_ch
// drops ready only once all four queue entries are occupied.
// Reset clears the pending run, the end flag, the queue and the output, and
// restores the register defaults (noise threshold 96, minimum run 24).
module carrier_run_coalescer import crc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    crc_in_if.sink               in_ch,
    crc_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t cfg_reg;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t q_head;

    // Register bank. Indexes past the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.noise_limit    <= NOISE_LIMIT_RST;
            cfg_reg.min_run_length <= MIN_RUN_LENGTH_RST;
            cfg_reg.blank_code     <= '0;
            cfg_reg.mark_code      <= '0;
            cfg_reg.space_code     <= '0;
            cfg_reg.data_code      <= '0;
            cfg_reg.end_code       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NOISE_LIMIT:     cfg_reg.noise_limit     <= cfg_data;
                CFG_MIN_RUN_LENGTH:  cfg_reg.min_run_length  <= cfg_data;
                CFG_BLANK_CODE:      cfg_reg.blank_code      <= cfg_data[15:0];
                CFG_MARK_CODE:       cfg_reg.mark_code       <= cfg_data[15:0];
                CFG_SPACE_CODE:      cfg_reg.space_code      <= cfg_data[15:0];
                CFG_DATA_CODE:       cfg_reg.data_code       <= cfg_data[15:0];
                CFG_END_CODE:        cfg_reg.end_code        <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front: run merging and command building.
    crc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue decoupling the two halves.
    crc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Back: record formatting and output register.
    crc_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule
